[src/ksm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the key-sequence pattern matcher.
// No dependencies; used by the interfaces, the top level and the checker.
package ksm_pkg;

  localparam int MAX_PATTERNS_DEF = 64;
  localparam int SEQ_LEN_DEF      = 5;
  localparam int KEY_BITS_DEF     = 16;

  localparam int CODE_W      = 16;
  localparam int IN_KEYS     = 5;
  localparam int SLOT_FIELD_W = 6;
  localparam int LEN_FIELD_W  = 3;

  localparam logic [CODE_W-1:0] ESC_CODE = 16'h0029;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_KEY   = 2'd2,
    CMD_START = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              tap_valid;
    logic [CODE_W-1:0] tap_keycode;
    logic              leading_now;
    logic              pass_on;
  } res_t;

endpackage

[src/ksm_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the matcher's item and result streams.
// Depends on ksm_pkg.
interface ksm_in_if;
  logic                        valid;
  logic                        ready;
  ksm_pkg::cmd_t               cmd;
  logic [ksm_pkg::SLOT_FIELD_W-1:0] entry_index;
  logic                        entry_valid;
  logic [ksm_pkg::LEN_FIELD_W-1:0]  entry_len;
  logic [ksm_pkg::CODE_W-1:0]  key_first;
  logic [ksm_pkg::CODE_W-1:0]  key_second;
  logic [ksm_pkg::CODE_W-1:0]  key_third;
  logic [ksm_pkg::CODE_W-1:0]  key_fourth;
  logic [ksm_pkg::CODE_W-1:0]  key_fifth;
  logic [ksm_pkg::CODE_W-1:0]  key_code;
  logic                        pressed;

  modport source (output valid, cmd, entry_index, entry_valid, entry_len, key_first,
                  key_second, key_third, key_fourth, key_fifth, key_code, pressed,
                  input ready);
  modport sink (input valid, cmd, entry_index, entry_valid, entry_len, key_first,
                key_second, key_third, key_fourth, key_fifth, key_code, pressed,
                output ready);
endinterface

interface ksm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       tap_valid;
  logic [ksm_pkg::CODE_W-1:0] tap_keycode;
  logic                       leading_now;
  logic                       pass_on;

  modport source (output valid, tap_valid, tap_keycode, leading_now, pass_on,
                  input ready);
  modport sink (input valid, tap_valid, tap_keycode, leading_now, pass_on,
                output ready);
endinterface

[src/key_sequence_pattern_matcher_top.sv]
`timescale 1ns / 1ps
// Key-sequence pattern matcher: a pattern table in RAM scanned by one key comparator.
// Depends on ksm_pkg, ksm_in_if / ksm_out_if and ksm_ram.
//
// Usage:
//   in_ch  (valid/ready) carries one command per transfer: load a table slot, check the
//          typed sequence, report a key event, or start leading.
//   out_ch (valid/ready) returns exactly one result per input transfer, in order.
// One item at a time; in_ch.ready is high only while idle.
//   Load, key event and start: the result is set up in the response state and moves to the
//   output register once that register is free; the block then returns to idle.
//   Check while leading: the sequencer walks the slots in order, skipping dead slots and
//   comparing live slots key by key until the first full match, since the single key
//   comparator tests one position per cycle against the registered RAM row.
// Reset: leading flag and all slot live bits clear at once; no clearing pass.
// Stall: a result waits in the output register; the block finishes the current item
//   and holds in its response state until the result register is free.
module key_sequence_pattern_matcher_top #(
  parameter int MAX_PATTERNS = ksm_pkg::MAX_PATTERNS_DEF,
  parameter int SEQ_LEN      = ksm_pkg::SEQ_LEN_DEF,
  parameter int KEY_BITS     = ksm_pkg::KEY_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ksm_in_if.sink   in_ch,
  ksm_out_if.source out_ch
);

  localparam int ADDR_SPAN = 1 << ksm_pkg::SLOT_FIELD_W;
  localparam int SLOTS  = (MAX_PATTERNS < ADDR_SPAN) ? MAX_PATTERNS : ADDR_SPAN;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int LEN_W  = $clog2(SEQ_LEN + 1);
  localparam int KIDX_W = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
  localparam int ROW_W  = LEN_W + SEQ_LEN * KEY_BITS + KEY_BITS;

  typedef enum logic [1:0] {S_IDLE, S_SLOT, S_CMP, S_RESP} state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           slot_r, slot_nxt;
  logic [LEN_W-1:0]           pos_r, pos_nxt;
  logic                       any_open_r, any_open_nxt;
  logic                       leading_r, leading_nxt;
  logic [SLOTS-1:0]           live_r, live_nxt;
  logic [KEY_BITS-1:0]        typed_r [SEQ_LEN];
  logic [KEY_BITS-1:0]        typed_nxt [SEQ_LEN];
  ksm_pkg::res_t              res_r, res_nxt;
  ksm_pkg::res_t              out_res_r, out_res_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [ksm_pkg::CODE_W-1:0] in_raw [ksm_pkg::IN_KEYS];
  logic [KEY_BITS-1:0]        in_keys [SEQ_LEN];
  logic [LEN_W-1:0]           len_sat;
  logic                       accept;
  logic                       out_free;
  logic                       slot_in_range;
  logic                       is_esc;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [ROW_W-1:0]           ram_wdata;
  logic                       ram_re;
  logic [ROW_W-1:0]           row;
  logic [LEN_W-1:0]           row_len;
  logic [KEY_BITS-1:0]        row_keys [SEQ_LEN];
  logic [KEY_BITS-1:0]        row_out;
  logic [KEY_BITS-1:0]        typed_k;
  logic [KEY_BITS-1:0]        pat_k;

  assign in_raw[0] = in_ch.key_first;
  assign in_raw[1] = in_ch.key_second;
  assign in_raw[2] = in_ch.key_third;
  assign in_raw[3] = in_ch.key_fourth;
  assign in_raw[4] = in_ch.key_fifth;

  always_comb begin
    for (int k = 0; k < SEQ_LEN; k++) begin
      if (k < ksm_pkg::IN_KEYS) begin
        in_keys[k] = in_raw[k][KEY_BITS-1:0];
      end else begin
        in_keys[k] = '0;
      end
    end
  end

  assign len_sat = (32'(in_ch.entry_len) > SEQ_LEN) ? LEN_W'(SEQ_LEN)
                                                     : LEN_W'(in_ch.entry_len);
  assign accept        = in_ch.valid && in_ch.ready;
  assign out_free      = !out_valid_r || out_ch.ready;
  assign slot_in_range = 32'(in_ch.entry_index) < SLOTS;
  assign is_esc        = ksm_pkg::CODE_W'(in_ch.key_code[KEY_BITS-1:0]) == ksm_pkg::ESC_CODE;

  // pattern table row: {output keycode, keys[SEQ_LEN-1..0], length}
  always_comb begin
    ram_wdata = '0;
    ram_wdata[LEN_W-1:0] = len_sat;
    for (int k = 0; k < SEQ_LEN; k++) begin
      ram_wdata[LEN_W + k*KEY_BITS +: KEY_BITS] = in_keys[k];
    end
    ram_wdata[ROW_W-1 -: KEY_BITS] = in_ch.key_code[KEY_BITS-1:0];
  end

  assign ram_we    = accept && (in_ch.cmd == ksm_pkg::CMD_LOAD) && slot_in_range;
  assign ram_waddr = in_ch.entry_index[IDX_W-1:0];
  assign ram_re    = (state_r == S_SLOT) && (slot_r != CNT_W'(SLOTS))
                     && live_r[slot_r[IDX_W-1:0]];

  ksm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_r[IDX_W-1:0]),
    .rdata (row)
  );

  always_comb begin
    row_len = row[LEN_W-1:0];
    for (int k = 0; k < SEQ_LEN; k++) begin
      row_keys[k] = row[LEN_W + k*KEY_BITS +: KEY_BITS];
    end
    row_out = row[ROW_W-1 -: KEY_BITS];
  end

  // shared comparator operands, one position per cycle
  assign typed_k = typed_r[pos_r[KIDX_W-1:0]];
  assign pat_k   = row_keys[pos_r[KIDX_W-1:0]];

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    pos_nxt       = pos_r;
    any_open_nxt  = any_open_r;
    leading_nxt   = leading_r;
    live_nxt      = live_r;
    typed_nxt     = typed_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          typed_nxt    = in_keys;
          slot_nxt     = '0;
          any_open_nxt = 1'b0;
          res_nxt      = '{tap_valid: 1'b0, tap_keycode: '0,
                           leading_now: leading_r, pass_on: 1'b1};
          state_nxt    = S_RESP;
          unique case (in_ch.cmd)
            ksm_pkg::CMD_LOAD: begin
              if (slot_in_range) begin
                live_nxt[in_ch.entry_index[IDX_W-1:0]] = in_ch.entry_valid;
              end
            end
            ksm_pkg::CMD_CHECK: begin
              if (leading_r) begin
                state_nxt = S_SLOT;
              end
            end
            ksm_pkg::CMD_KEY: begin
              if (leading_r && is_esc && in_ch.pressed) begin
                leading_nxt         = 1'b0;
                res_nxt.leading_now = 1'b0;
                res_nxt.pass_on     = 1'b0;
              end
            end
            ksm_pkg::CMD_START: begin
              leading_nxt         = 1'b1;
              res_nxt.leading_now = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SLOT: begin
        if (slot_r == CNT_W'(SLOTS)) begin
          leading_nxt = any_open_r;
          res_nxt     = '{tap_valid: 1'b0, tap_keycode: '0,
                          leading_now: any_open_r, pass_on: 1'b1};
          state_nxt   = S_RESP;
        end else if (live_r[slot_r[IDX_W-1:0]]) begin
          pos_nxt   = '0;
          state_nxt = S_CMP;
        end else begin
          slot_nxt = slot_r + CNT_W'(1);
        end
      end
      S_CMP: begin
        if (pos_r >= row_len) begin
          leading_nxt = 1'b0;
          res_nxt     = '{tap_valid: 1'b1, tap_keycode: ksm_pkg::CODE_W'(row_out),
                          leading_now: 1'b0, pass_on: 1'b1};
          state_nxt   = S_RESP;
        end else if (typed_k == '0) begin
          any_open_nxt = 1'b1;
          slot_nxt     = slot_r + CNT_W'(1);
          state_nxt    = S_SLOT;
        end else if (typed_k != pat_k) begin
          slot_nxt  = slot_r + CNT_W'(1);
          state_nxt = S_SLOT;
        end else begin
          pos_nxt = pos_r + LEN_W'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      leading_r   <= 1'b0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      leading_r   <= leading_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r     <= slot_nxt;
    pos_r      <= pos_nxt;
    any_open_r <= any_open_nxt;
    typed_r    <= typed_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.tap_valid    = out_res_r.tap_valid;
  assign out_ch.tap_keycode  = out_res_r.tap_keycode;
  assign out_ch.leading_now  = out_res_r.leading_now;
  assign out_ch.pass_on      = out_res_r.pass_on;

endmodule

[src/ksm_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ksm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/ksm_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for the key-sequence pattern matcher, bound to the top level.
// Depends on ksm_pkg and key_sequence_pattern_matcher_top.
module ksm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_tap_valid,
  input logic [ksm_pkg::CODE_W-1:0] out_tap_keycode,
  input logic                       out_leading_now,
  input logic                       out_pass_on
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tap_valid) && $stable(out_tap_keycode)
                                && $stable(out_leading_now) && $stable(out_pass_on))
    else $error("result changed while stalled");

  a_tap_ends_leading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tap_valid |-> !out_leading_now && out_pass_on)
    else $error("tap without leaving leading");

  a_no_tap_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tap_valid |-> out_tap_keycode == '0)
    else $error("keycode without tap");

  a_consume_ends_leading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pass_on |-> !out_leading_now && !out_tap_valid)
    else $error("consumed escape left leading set");

endmodule

bind key_sequence_pattern_matcher_top ksm_checker u_ksm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_tap_valid   (out_ch.tap_valid),
  .out_tap_keycode (out_ch.tap_keycode),
  .out_leading_now (out_ch.leading_now),
  .out_pass_on     (out_ch.pass_on)
);
